// ===== hdl/bap_pkg.sv =====
`timescale 1ns / 1ps

package bap_pkg;

  // CORDIC iteration count; values above MAX_STEPS act as MAX_STEPS
  localparam int ANGLE_STEPS  = 24;
  localparam int MAX_STEPS    = 40;
  localparam int CORDIC_STEPS = (ANGLE_STEPS < MAX_STEPS) ? ANGLE_STEPS : MAX_STEPS;

  // back pipeline: squares at stage 1, sum at stage 2, one root bit per stage after that
  localparam int SQRT_BITS  = 32;
  localparam int SQRT_FIRST = 3;
  localparam int SQRT_LAST  = SQRT_FIRST + SQRT_BITS - 1;
  localparam int BACK_LAST  = (SQRT_LAST > CORDIC_STEPS) ? SQRT_LAST : CORDIC_STEPS;

  // CORDIC datapath widths
  localparam int XW          = 35;
  localparam int ZW          = 27;
  localparam int ANGLE_FRAC  = 16;
  localparam int HALF_TURN   = 180 << ANGLE_FRAC;
  localparam int PHASE_SHIFT = 9;
  localparam int PHASE_LIMIT = 23040;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic signed [15:0] first_real;
    logic signed [15:0] first_imag;
    logic signed [15:0] second_real;
    logic signed [15:0] second_imag;
    logic signed [15:0] third_real;
    logic signed [15:0] third_imag;
  } in_t;

  typedef struct packed {
    logic signed [31:0] product_real;
    logic signed [31:0] product_imag;
    logic        [30:0] amplitude;
    logic signed [15:0] phase_degrees;
  } out_t;

  // truncated Q3.29 triple product handed from front to back
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } prod_t;

  // atan(2^-i) in units of 1/65536 degree
  function automatic int atan_deg(input int i);
    int v;
    case (i)
      0:       v = 2949120;
      1:       v = 1740967;
      2:       v = 919879;
      3:       v = 466945;
      4:       v = 234379;
      5:       v = 117304;
      6:       v = 58666;
      7:       v = 29335;
      8:       v = 14668;
      9:       v = 7334;
      10:      v = 3667;
      11:      v = 1833;
      12:      v = 917;
      13:      v = 458;
      14:      v = 229;
      15:      v = 115;
      16:      v = 57;
      17:      v = 29;
      18:      v = 14;
      19:      v = 7;
      20:      v = 4;
      21:      v = 2;
      22:      v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/bap_front.sv =====
`timescale 1ns / 1ps

module bap_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  bap_pkg::in_t    item,
  output logic            q_valid,
  input  logic            q_ready,
  output bap_pkg::prod_t  q_data
);

  // stage 1: V1*V2 partial products
  logic               v1;
  logic signed [31:0] rr, ii, ri, ir;
  logic signed [15:0] re3_1, im3_1;
  // stage 2: V1*V2 in Q2.30
  logic               v2;
  logic signed [32:0] pr, pi;
  logic signed [15:0] re3_2, im3_2;
  // stage 3: times conj(V3) partial products
  logic               v3;
  logic signed [48:0] m_a, m_b, m_c, m_d;
  // stage 4: truncated result
  logic               v4;
  bap_pkg::prod_t     res;

  logic               adv;
  logic signed [49:0] br, bi, brs, bis;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic fits;
    fits = (&v[49:31]) | ~(|v[49:31]);
    if (fits) begin
      return v[31:0];
    end else if (v[49]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  assign adv        = !v4 || q_ready;
  assign item_ready = adv;

  assign br  = 50'(m_a) + 50'(m_b);
  assign bi  = 50'(m_c) - 50'(m_d);
  assign brs = br >>> 16;
  assign bis = bi >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rr    <= item.first_real * item.second_real;
      ii    <= item.first_imag * item.second_imag;
      ri    <= item.first_real * item.second_imag;
      ir    <= item.first_imag * item.second_real;
      re3_1 <= item.third_real;
      im3_1 <= item.third_imag;

      pr    <= 33'(rr) - 33'(ii);
      pi    <= 33'(ri) + 33'(ir);
      re3_2 <= re3_1;
      im3_2 <= im3_1;

      m_a   <= pr * re3_2;
      m_b   <= pi * im3_2;
      m_c   <= pi * re3_2;
      m_d   <= pr * im3_2;

      res.re <= sat32(brs);
      res.im <= sat32(bis);
    end
  end

  assign q_valid = v4;
  assign q_data  = res;

endmodule

// ===== hdl/bap_fifo.sv =====
`timescale 1ns / 1ps

module bap_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  bap_pkg::prod_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output bap_pkg::prod_t  rd_data
);

  localparam int CW = bap_pkg::FIFO_AW + 1;

  bap_pkg::prod_t              mem [bap_pkg::FIFO_DEPTH];
  logic [bap_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0]               count;
  logic                        push, pop;

  assign wr_ready = count != CW'(bap_pkg::FIFO_DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hdl/bap_back.sv =====
`timescale 1ns / 1ps

module bap_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  bap_pkg::prod_t  q_data,
  output logic            result_valid,
  input  logic            result_ready,
  output bap_pkg::out_t   result
);

  localparam int LAST = bap_pkg::BACK_LAST;
  localparam int XW   = bap_pkg::XW;
  localparam int ZW   = bap_pkg::ZW;

  // sa/sb: magnitudes, then squares, then remainder and root
  typedef struct packed {
    logic [63:0]          sa;
    logic [63:0]          sb;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    bap_pkg::prod_t       p;
  } back_t;

  back_t  st  [LAST+1];
  logic   vld [LAST+1];
  logic   adv;

  logic [32:0]          abs_re, abs_im;
  logic signed [XW-1:0] re_x, im_x;
  back_t                st0_next;

  bap_pkg::out_t        out_next;
  logic signed [ZW-1:0] z_rnd, z_sh;

  assign adv     = !result_valid || result_ready;
  assign q_ready = adv;

  // entry: magnitudes for the root, half-plane reflection for CORDIC
  assign abs_re = q_data.re[31] ? -33'(q_data.re) : 33'(q_data.re);
  assign abs_im = q_data.im[31] ? -33'(q_data.im) : 33'(q_data.im);
  assign re_x   = XW'(q_data.re);
  assign im_x   = XW'(q_data.im);

  always_comb begin
    st0_next.sa   = {32'd0, abs_re[31:0]};
    st0_next.sb   = {32'd0, abs_im[31:0]};
    st0_next.zero = (q_data.re == '0) && (q_data.im == '0);
    st0_next.p    = q_data;
    if (q_data.re[31]) begin
      st0_next.x = -re_x;
      st0_next.y = -im_x;
      st0_next.z = q_data.im[31] ? -ZW'(bap_pkg::HALF_TURN) : ZW'(bap_pkg::HALF_TURN);
    end else begin
      st0_next.x = re_x;
      st0_next.y = im_x;
      st0_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st0_next;
    end
  end

  for (genvar gk = 1; gk <= LAST; gk++) begin : g_stage
    back_t                cur, nxt;
    logic [63:0]          sa_n, sb_n;
    logic signed [XW-1:0] x_n, y_n;
    logic signed [ZW-1:0] z_n;

    assign cur = st[gk-1];

    if (gk == 1) begin : g_square
      logic [31:0] fa, fb;
      assign fa   = cur.sa[31:0];
      assign fb   = cur.sb[31:0];
      assign sa_n = fa * fa;
      assign sb_n = fb * fb;
    end else if (gk == 2) begin : g_sum
      assign sa_n = cur.sa + cur.sb;
      assign sb_n = '0;
    end else if (gk >= bap_pkg::SQRT_FIRST && gk <= bap_pkg::SQRT_LAST) begin : g_root
      localparam int          J   = gk - bap_pkg::SQRT_FIRST;
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * J);
      logic [64:0] trial;
      logic        take;
      assign trial = 65'(cur.sb) + 65'(BIT);
      assign take  = 65'(cur.sa) >= trial;
      assign sa_n  = take ? cur.sa - trial[63:0] : cur.sa;
      assign sb_n  = take ? (cur.sb >> 1) + BIT : cur.sb >> 1;
    end else begin : g_root_pass
      assign sa_n = cur.sa;
      assign sb_n = cur.sb;
    end

    if (gk <= bap_pkg::CORDIC_STEPS) begin : g_cordic
      localparam int                I    = gk - 1;
      localparam logic signed [ZW-1:0] ATAN = ZW'(bap_pkg::atan_deg(I));
      logic signed [XW-1:0] xs, ys;
      assign xs  = cur.x >>> I;
      assign ys  = cur.y >>> I;
      assign x_n = cur.y[XW-1] ? cur.x - ys : cur.x + ys;
      assign y_n = cur.y[XW-1] ? cur.y + xs : cur.y - xs;
      assign z_n = cur.y[XW-1] ? cur.z - ATAN : cur.z + ATAN;
    end else begin : g_cordic_pass
      assign x_n = cur.x;
      assign y_n = cur.y;
      assign z_n = cur.z;
    end

    always_comb begin
      nxt    = cur;
      nxt.sa = sa_n;
      nxt.sb = sb_n;
      nxt.x  = x_n;
      nxt.y  = y_n;
      nxt.z  = z_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[gk] <= 1'b0;
      end else if (adv) begin
        vld[gk] <= vld[gk-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[gk] <= nxt;
      end
    end
  end

  // round half up to 1/128 degree, saturate, clamp the root
  assign z_rnd = st[LAST].z + ZW'(1 << (bap_pkg::PHASE_SHIFT - 1));
  assign z_sh  = z_rnd >>> bap_pkg::PHASE_SHIFT;

  always_comb begin
    out_next.product_real = st[LAST].p.re;
    out_next.product_imag = st[LAST].p.im;
    if (|st[LAST].sb[63:31]) begin
      out_next.amplitude = 31'h7FFF_FFFF;
    end else begin
      out_next.amplitude = st[LAST].sb[30:0];
    end
    if (st[LAST].zero) begin
      out_next.phase_degrees = '0;
    end else if (z_sh > ZW'(bap_pkg::PHASE_LIMIT)) begin
      out_next.phase_degrees = 16'(bap_pkg::PHASE_LIMIT);
    end else if (z_sh < -ZW'(bap_pkg::PHASE_LIMIT)) begin
      out_next.phase_degrees = -16'(bap_pkg::PHASE_LIMIT);
    end else begin
      out_next.phase_degrees = z_sh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= out_next;
    end
  end

endmodule

// ===== hdl/bispectrum_amp_phase.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle; a stalled output fills the 4-entry queue before input stalls.
// The back half runs the 32-stage root pipeline (one root bit per stage) beside the CORDIC stages.
// Reset: synchronous, active high; clears stage valids, queue pointers and result_valid.
// No clearing pass; the block accepts beats as soon as reset is released.

module bispectrum_amp_phase (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  bap_pkg::in_t   item,
  output logic           result_valid,
  input  logic           result_ready,
  output bap_pkg::out_t  result
);

  // front: complex products V1*V2*conj(V3), four stages, truncated to Q3.29
  bap_pkg::prod_t f_data;
  logic           f_valid, f_ready;

  // back: magnitude root and CORDIC phase, fed from the queue
  bap_pkg::prod_t b_data;
  logic           b_valid, b_ready;

  bap_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_data     (f_data)
  );

  // queue decouples the two halves; its ready comes from a registered count
  bap_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  bap_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (b_valid),
    .q_ready      (b_ready),
    .q_data       (b_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Checks the bispectrum block: the triple product V1*V2*conj(V3) in Q3.29,
// its floor-root magnitude and its CORDIC phase in 1/128 degree.
// Stimulus runs as a chain of test tasks that all push beats through
// send_triple. A scoreboard queue holds the predicted results, and the
// process that drives result_ready pops and compares one entry per result
// beat.
module tb_top;

  // input beat to result beat, in cycles
  localparam int PIPE_LATENCY =
    7 + ((bap_pkg::CORDIC_STEPS > 34) ? bap_pkg::CORDIC_STEPS : 34);
  localparam longint HALF_TURN_Z = longint'(180) <<< 16;   // 180 deg in 1/65536 deg
  localparam longint PHASE_MAX   = 23040;                  // 180 deg in 1/128 deg

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          item_valid = 1'b0;
  logic          item_ready;
  bap_pkg::in_t  item = '0;
  logic          result_valid;
  logic          result_ready = 1'b0;
  bap_pkg::out_t result;

  bap_pkg::out_t bispectra_due[$];   // predicted results, oldest first
  int            mismatches = 0;

  // both sides can be told to stop idling for a back-to-back stretch
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  int   stall_left = 0;

  // atan(2^-i) in 1/65536 degree
  longint atan_step_deg [0:39] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  bispectrum_amp_phase dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // floor square root, one result bit per pass
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // CORDIC vectoring on the truncated parts; angle kept in 1/65536 deg
  function automatic logic signed [15:0] closure_phase(longint re, longint im);
    longint x, y, z, xs, ys;
    x = re;
    y = im;
    z = 0;
    if (x == 0 && y == 0) return '0;
    // left half plane: reflect through the origin, start from +-180
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < bap_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step_deg[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step_deg[i];
      end
    end
    // round half up to 1/128 deg, residue may overshoot 180
    z = (z + 256) >>> 9;
    return 16'(clamp(z, -PHASE_MAX, PHASE_MAX));
  endfunction

  function automatic bap_pkg::out_t triple_product(bap_pkg::in_t v);
    longint r1, i1, r2, i2, r3, i3;
    longint pr, pi, br, bi, re, im;
    longint unsigned mag;
    bap_pkg::out_t o;
    r1 = longint'(v.first_real);
    i1 = longint'(v.first_imag);
    r2 = longint'(v.second_real);
    i2 = longint'(v.second_imag);
    r3 = longint'(v.third_real);
    i3 = longint'(v.third_imag);
    // V1*V2 in Q2.30, then times conj(V3) in Q3.45
    pr = r1 * r2 - i1 * i2;
    pi = r1 * i2 + i1 * r2;
    br = pr * r3 + pi * i3;
    bi = pi * r3 - pr * i3;
    // floor to Q3.29
    re = clamp(br >>> 16, -64'sd2147483648, 64'sd2147483647);
    im = clamp(bi >>> 16, -64'sd2147483648, 64'sd2147483647);
    mag = floor_root(longint'(unsigned'(re * re)) + longint'(unsigned'(im * im)));
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    o.product_real  = 32'(re);
    o.product_imag  = 32'(im);
    o.amplitude     = 31'(mag);
    o.phase_degrees = closure_phase(re, im);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls on result_ready, scoreboard compare
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (bispectra_due.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatches++;
        end else begin
          bap_pkg::out_t want;
          want = bispectra_due.pop_front();
          if (result.product_real !== want.product_real) begin
            $error("product_real: expected %0d, got %0d", want.product_real,
                   result.product_real);
            mismatches++;
          end
          if (result.product_imag !== want.product_imag) begin
            $error("product_imag: expected %0d, got %0d", want.product_imag,
                   result.product_imag);
            mismatches++;
          end
          if (result.amplitude !== want.amplitude) begin
            $error("amplitude: expected %0d, got %0d", want.amplitude, result.amplitude);
            mismatches++;
          end
          if (result.phase_degrees !== want.phase_degrees) begin
            $error("phase_degrees: expected %0d, got %0d", want.phase_degrees,
                   result.phase_degrees);
            mismatches++;
          end
        end
      end
      // stalls: random runs of low ready, now and then a long one; none while rx_calm is set
      if (rx_calm) begin
        stall_left = 0;
        result_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2:  stall_left = $urandom_range(1, 3);
          3:        stall_left = $urandom_range(15, 60);
          default:  stall_left = 0;
        endcase
        result_ready <= (stall_left == 0);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  function automatic int idle_cycles();
    if (tx_calm) return 0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return $urandom_range(1, 3);
      5:             return $urandom_range(10, 40);
      default:       return 0;
    endcase
  endfunction

  // one input beat; valid stays high into the next call when no gap follows
  task automatic send_triple(input bap_pkg::in_t beat);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    bispectra_due.push_back(triple_product(beat));
  endtask

  task automatic wait_drained();
    while (bispectra_due.size() != 0) @(posedge clk);
  endtask

  function automatic bap_pkg::in_t triple(int r1, int i1, int r2, int i2, int r3, int i3);
    bap_pkg::in_t v;
    v.first_real  = 16'(r1);
    v.first_imag  = 16'(i1);
    v.second_real = 16'(r2);
    v.second_imag = 16'(i2);
    v.third_real  = 16'(r3);
    v.third_imag  = 16'(i3);
    return v;
  endfunction

  // field value biased toward the edges of Q1.15 and toward values near zero
  function automatic int shaped_part();
    case ($urandom_range(0, 9))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return int'($urandom_range(0, 16)) - 8;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_directed();
    // zero in, zero product after truncation
    send_triple(triple(0, 0, 0, 0, 0, 0));
    send_triple(triple(1, 1, 1, 0, 1, 0));
    // full-scale corners
    send_triple(triple(-32768, -32768, -32768, -32768, -32768, -32768));
    send_triple(triple(32767, 32767, 32767, 32767, 32767, 32767));
    send_triple(triple(-32768, 32767, -32768, 32767, 32767, -32768));
    send_triple(triple(32767, -32768, 32767, -32768, -32768, 32767));
    send_triple(triple(-32768, 0, -32768, 0, -32768, 0));
    send_triple(triple(32767, 0, 32767, 0, 32767, 0));
    // closing visibility zero kills the product
    send_triple(triple(32767, -32768, 12345, -777, 0, 0));
    // axes: +re, -re (180 deg), +im, -im
    send_triple(triple(16384, 0, 16384, 0, 16384, 0));
    send_triple(triple(-16384, 0, 16384, 0, 16384, 0));
    send_triple(triple(0, 16384, 16384, 0, 16384, 0));
    send_triple(triple(0, -16384, 16384, 0, 16384, 0));
    // left half plane, imaginary part on either side of zero
    send_triple(triple(-20000, 300, 30000, 0, 30000, 0));
    send_triple(triple(-20000, -300, 30000, 0, 30000, 0));
    // floor of tiny negatives: -1 lands at 180, -135 and -90 deg
    send_triple(triple(-1, 0, 1, 0, 1, 0));
    send_triple(triple(-1, -1, 1, 0, 1, 0));
    send_triple(triple(1, -1, 1, 0, 1, 0));
    // near +-180, where the CORDIC residue may overshoot
    send_triple(triple(-32768, 1, 32767, 0, 32767, 0));
    send_triple(triple(-32768, -1, 32767, 0, 32767, 0));
    // conjugation check: V3's angle is subtracted, so equal angles on V1 and V3 cancel
    send_triple(triple(23170, 23170, 32767, 0, 23170, 23170));
    send_triple(triple(-23170, 23170, 0, -32768, 23170, -23170));
  endtask

  task automatic test_uniform_random(int count);
    repeat (count)
      send_triple(bap_pkg::in_t'({$urandom, $urandom, $urandom}));
  endtask

  task automatic test_shaped_random(int count);
    bap_pkg::in_t v;
    repeat (count) begin
      v = triple(shaped_part(), shaped_part(), shaped_part(),
                 shaped_part(), shaped_part(), shaped_part());
      // a share stays on the real axis, so the product does too
      if ($urandom_range(0, 4) == 0) begin
        v.first_imag  = '0;
        v.second_imag = '0;
        v.third_imag  = '0;
      end
      send_triple(v);
    end
  endtask

  // sender holds off until the block has emptied, then resumes
  task automatic test_drain_pause();
    test_uniform_random(40);
    item_valid <= 1'b0;
    wait_drained();
    test_shaped_random(40);
  endtask

  // no idling on either side: full rate, queue never backs up
  task automatic test_back_to_back(int count);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    test_uniform_random(count);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_uniform_random(300);
    test_drain_pause();
    test_shaped_random(450);
    test_back_to_back(150);

    item_valid <= 1'b0;
    wait_drained();
    // stray late beats would show up here as unexpected results
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #1500000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
